>>> hdl/crc_checked_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC checked frame deframer
// Concurrent checks for simulation; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define CCFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccfd assertion failed");

// next-cycle implication, disabled during reset
`define CCFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccfd assertion failed");

`else

`define CCFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CCFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/ccfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfd_pkg
// Shared constants and types of the CRC checked frame deframer.
// ----------------------------------------------------------------------------
package ccfd_pkg;

  localparam logic [15:0] START_MARKER_RESET = 16'h6655;
  localparam logic [15:0] CRC_POLY           = 16'h1021;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BADMARK = 2'd2,
    ST_CRCBAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_ctrl;
    logic [15:0] frame_seq;
    logic [7:0]  frame_cmd;
    logic [15:0] payload_length;
    status_t     status;
  } result_t;

endpackage

>>> hdl/ccfd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfd_byte_if
// Datagram byte channel: one byte and its end-of-datagram mark per transfer.
// ----------------------------------------------------------------------------
interface ccfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, data_byte, end_of_datagram, input ready);
  modport sink   (input valid, data_byte, end_of_datagram, output ready);
endinterface

>>> hdl/ccfd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfd_result_if
// Result channel: a payload byte or a frame status per transfer.
// ----------------------------------------------------------------------------
interface ccfd_result_if import ccfd_pkg::*; ;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_ctrl;
  logic [15:0] frame_seq;
  logic [7:0]  frame_cmd;
  logic [15:0] payload_length;
  status_t     status;

  modport source (output valid, is_status, payload_byte, frame_ctrl, frame_seq,
                  frame_cmd, payload_length, status, input ready);
  modport sink   (input valid, is_status, payload_byte, frame_ctrl, frame_seq,
                  frame_cmd, payload_length, status, output ready);
endinterface

>>> hdl/ccfd_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfd_crc_byte
// Byte-wide CRC16-XMODEM update, MSB first, unrolled over eight bits.
// ----------------------------------------------------------------------------
module ccfd_crc_byte import ccfd_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

>>> hdl/ccfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfd_parser
// Frame state machine: header capture, payload forwarding, CRC check.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_deframer_defines.svh"

module ccfd_parser import ccfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [15:0] start_marker,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_LO  = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_SKIP    = 3'd5,
    PH_BADMARK = 3'd6
  } phase_t;

  localparam logic [15:0] POS_MARKER_HI = 16'd1;
  localparam logic [15:0] POS_CTRL      = 16'd2;
  localparam logic [15:0] POS_LEN_LO    = 16'd3;
  localparam logic [15:0] POS_LEN_HI    = 16'd4;
  localparam logic [15:0] POS_SEQ_LO    = 16'd5;
  localparam logic [15:0] POS_SEQ_HI    = 16'd6;
  localparam logic [15:0] POS_BAD_LAST  = 16'd9;

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_ctrl, held_ctrl_next;
  logic [15:0] held_seq, held_seq_next;
  logic [7:0]  held_cmd, held_cmd_next;
  logic [15:0] held_length, held_length_next;
  logic [7:0]  held_low_byte, held_low_byte_next;

  logic [15:0] crc_seed, crc_upd;
  logic [15:0] pos_inc;
  logic        emit_status, emit_payload;
  status_t     code;

  assign crc_seed = (phase == PH_FIRST) ? 16'h0000 : running_crc;
  assign pos_inc  = byte_position + 16'd1;

  ccfd_crc_byte u_crc (
    .crc_in  (crc_seed),
    .data    (data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    held_ctrl_next     = held_ctrl;
    held_seq_next      = held_seq;
    held_cmd_next      = held_cmd;
    held_length_next   = held_length;
    held_low_byte_next = held_low_byte;
    emit_status        = 1'b0;
    emit_payload       = 1'b0;
    code               = ST_SHORT;

    unique case (phase)
      PH_FIRST: begin
        held_ctrl_next     = 8'h00;
        held_seq_next      = 16'h0000;
        held_cmd_next      = 8'h00;
        held_length_next   = 16'h0000;
        held_low_byte_next = data_byte;
        running_crc_next   = crc_upd;
        byte_position_next = 16'd1;
        phase_next         = PH_HEADER;
        emit_status        = last;
      end
      PH_HEADER: begin
        running_crc_next = crc_upd;
        unique case (byte_position)
          POS_MARKER_HI: begin
            if ({data_byte, held_low_byte} != start_marker) phase_next = PH_BADMARK;
          end
          POS_CTRL:   held_ctrl_next = data_byte;
          POS_LEN_LO: held_low_byte_next = data_byte;
          POS_LEN_HI: held_length_next = {data_byte, held_low_byte};
          POS_SEQ_LO: held_low_byte_next = data_byte;
          POS_SEQ_HI: held_seq_next = {data_byte, held_low_byte};
          default: begin
            held_cmd_next = data_byte;
            phase_next    = (held_length == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
          end
        endcase
        byte_position_next = (phase_next == PH_PAYLOAD) ? 16'd0 : pos_inc;
        emit_status        = last;
      end
      PH_PAYLOAD: begin
        running_crc_next   = crc_upd;
        byte_position_next = pos_inc;
        if (pos_inc == held_length) phase_next = PH_CRC_LO;
        emit_status  = last;
        emit_payload = !last;
      end
      PH_CRC_LO: begin
        held_low_byte_next = data_byte;
        phase_next         = PH_CRC_HI;
        emit_status        = last;
      end
      PH_CRC_HI: begin
        emit_status = 1'b1;
        code = ({data_byte, held_low_byte} == running_crc) ? ST_OK : ST_CRCBAD;
      end
      PH_BADMARK: begin
        if (byte_position >= POS_BAD_LAST) begin
          emit_status = 1'b1;
          code        = ST_BADMARK;
        end else begin
          byte_position_next = pos_inc;
          emit_status        = last;
        end
      end
      default: begin
        if (last) phase_next = PH_FIRST;
      end
    endcase

    // a status ends the frame: wait for the end mark unless this is it
    if (emit_status) phase_next = last ? PH_FIRST : PH_SKIP;
  end

  always_comb begin
    res_valid = emit_status || emit_payload;
    res       = '0;
    if (emit_status) begin
      res.is_status      = 1'b1;
      res.frame_ctrl     = held_ctrl_next;
      res.frame_seq      = held_seq_next;
      res.frame_cmd      = held_cmd_next;
      res.payload_length = held_length_next;
      res.status         = code;
    end else begin
      res.payload_byte   = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      byte_position <= 16'd0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      held_ctrl     <= held_ctrl_next;
      held_seq      <= held_seq_next;
      held_cmd      <= held_cmd_next;
      held_length   <= held_length_next;
      held_low_byte <= held_low_byte_next;
    end
  end

  `CCFD_ASSERT_IMPL(a_payload_only_in_payload, clk, rst,
    step && res_valid && !res.is_status, phase == PH_PAYLOAD)
  `CCFD_ASSERT_NEXT(a_status_ends_frame, clk, rst,
    step && res_valid && res.is_status, phase == PH_FIRST || phase == PH_SKIP)
  `CCFD_ASSERT_IMPL(a_badmark_from_badmark, clk, rst,
    step && res_valid && res.is_status && res.status == ST_BADMARK,
    phase == PH_BADMARK)
  `CCFD_ASSERT_IMPL(a_badmark_position, clk, rst,
    phase == PH_BADMARK, byte_position >= POS_CTRL && byte_position <= POS_BAD_LAST)

endmodule

>>> hdl/crc_checked_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// Parses framed datagrams, forwards payload and reports one status per frame.
// ----------------------------------------------------------------------------
// Sustains one byte per clock while results are taken: a byte transfer can be
// taken in every cycle, and each transferred byte passes the input register
// and then the result register. A result left waiting holds the parser; the
// byte channel takes one more byte into the input register and then stalls
// until the result is taken. The byte-wide CRC16-XMODEM update and the frame
// state machine sit together between those two registers. Each datagram
// yields exactly one status transfer; payload bytes are forwarded as they
// arrive, before the CRC is known, so discard the payload of any frame whose
// status is not ok. Write the start marker only while the block is idle.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_deframer_defines.svh"

module crc_checked_frame_deframer import ccfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ccfd_byte_if.sink   datagram,
  ccfd_result_if.source result,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] start_marker;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // result register
  logic    out_valid;
  result_t out_data;

  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;

  // result register is free when empty or being drained this cycle
  assign out_free       = !out_valid || result.ready;
  // consume the held byte whenever its result, if any, has room
  assign step           = s1_valid && out_free;
  assign datagram.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
    end else if (cfg_wr_en) begin
      start_marker <= cfg_wr_data;
    end
  end

  // hold the incoming byte until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (datagram.ready) begin
      s1_valid <= datagram.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (datagram.valid && datagram.ready) begin
      s1_byte <= datagram.data_byte;
      s1_last <= datagram.end_of_datagram;
    end
  end

  ccfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (s1_byte),
    .last         (s1_last),
    .start_marker (start_marker),
    .res_valid    (res_valid),
    .res          (res)
  );

  // advance the result register; bytes that give no result leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.is_status      = out_data.is_status;
  assign result.payload_byte   = out_data.payload_byte;
  assign result.frame_ctrl     = out_data.frame_ctrl;
  assign result.frame_seq      = out_data.frame_seq;
  assign result.frame_cmd      = out_data.frame_cmd;
  assign result.payload_length = out_data.payload_length;
  assign result.status         = out_data.status;

  `CCFD_ASSERT_IMPL(a_full_input_needs_drain, clk, rst,
    s1_valid && datagram.ready, out_free)
  `CCFD_ASSERT_NEXT(a_result_loaded, clk, rst,
    step && res_valid, out_valid)

endmodule
